// File: design/wpng_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpng_pkg
// Shared constants, types and helpers of the white and pink noise generator.
// ----------------------------------------------------------------------------
package wpng_pkg;

   localparam int TABLE_SIZE = 4093;
   localparam int VOICES     = 8;

   localparam int VOICE_W  = 3;
   localparam int VOICE_AW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int PHASE_W  = 28;
   localparam int FRAC_W   = 16;
   localparam int SUM_W    = PHASE_W + 1;
   localparam int ROM_AW   = $clog2(TABLE_SIZE);
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;
   localparam int Q15_W    = 15;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;
   localparam int XS_W     = 32;

   localparam int PROD_W = COEF_W + SAMPLE_W + 2;
   localparam int ACC_W  = PROD_W + 1;
   localparam int Q_W    = ACC_W - Q15_W;

   localparam logic [SUM_W-1:0]   WRAP_ONE   = SUM_W'(TABLE_SIZE) << FRAC_W;
   localparam logic [SUM_W-1:0]   WRAP_TWO   = WRAP_ONE << 1;
   localparam logic [XS_W-1:0]    NOISE_SEED = 32'hA5C3412F;
   localparam logic [PHASE_W-1:0] STEP_RESET = 28'd60817408;
   localparam logic [COEF_W-1:0]  COEF_RESET = 16'd32113;
   localparam logic [ROM_AW-1:0]  ROM_LAST   = ROM_AW'(TABLE_SIZE - 1);

   typedef enum logic [0:0] {
      REG_NOISE_STEP = 1'b0,
      REG_PINK_COEF  = 1'b1
   } csr_index_type;

   function automatic logic [XS_W-1:0] xorshift_next(input logic [XS_W-1:0] s);
      logic [XS_W-1:0] t;
      t = s ^ (s << 13);
      t = t ^ (t >> 17);
      t = t ^ (t << 5);
      return t;
   endfunction

endpackage

// File: design/wpng_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpng_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module wpng_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/white_pink_noise_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// white_pink_noise_generator_unit
// Table white noise per voice with a shared one-pole pink filter.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req       in         req_valid/ready    req_voice
//  rsp       out        rsp_valid/ready    rsp_white, rsp_pink
//  csr       in         apb psel/penable   paddr, pwdata, prdata
//
//  one request per cycle unless stalled; the response is registered after
//  the phase ram read, then the noise ram read and pink filter multiply-add
//  after reset all 4093 noise ram entries are filled with req_ready low
//  rsp_ready low holds the response; up to three requests stay in flight
// ----------------------------------------------------------------------------
module white_pink_noise_generator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [wpng_pkg::VOICE_W-1:0]        req_voice,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [wpng_pkg::SAMPLE_W-1:0] rsp_white,
   output logic signed [wpng_pkg::SAMPLE_W-1:0] rsp_pink,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [wpng_pkg::CSR_AW-1:0]         paddr,
   input  logic [wpng_pkg::CSR_DW-1:0]         pwdata,
   output logic [wpng_pkg::CSR_DW-1:0]         prdata,
   output logic                                pready
);

   import wpng_pkg::*;

   // configuration registers
   logic [PHASE_W-1:0] step_ff, step_in;
   logic [COEF_W-1:0]  coef_ff, coef_in;
   logic               csr_wr;
   csr_index_type      csr_idx;

   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = csr_index_type'(paddr[2]);
   assign pready  = 1'b1;

   always_comb begin
      step_in = step_ff;
      coef_in = coef_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_NOISE_STEP: step_in = pwdata[PHASE_W-1:0];
            REG_PINK_COEF:  coef_in = pwdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_NOISE_STEP: prdata = CSR_DW'(step_ff);
         REG_PINK_COEF:  prdata = CSR_DW'(coef_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
         coef_ff <= COEF_RESET;
      end else begin
         step_ff <= step_in;
         coef_ff <= coef_in;
      end
   end

   // noise table fill after reset
   logic              fill_ff, fill_in;
   logic [ROM_AW-1:0] fill_addr_ff, fill_addr_in;
   logic [XS_W-1:0]   xs_ff, xs_in;
   logic [XS_W-1:0]   xs_next;

   assign xs_next = xorshift_next(xs_ff);

   always_comb begin
      fill_in      = fill_ff;
      fill_addr_in = fill_addr_ff;
      xs_in        = xs_ff;
      if (fill_ff) begin
         xs_in        = xs_next;
         fill_addr_in = fill_addr_ff + 1'b1;
         if (fill_addr_ff == ROM_LAST) begin
            fill_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= 1'b1;
         fill_addr_ff <= '0;
         xs_ff        <= NOISE_SEED;
      end else begin
         fill_ff      <= fill_in;
         fill_addr_ff <= fill_addr_in;
         xs_ff        <= xs_in;
      end
   end

   // pipeline control
   logic                s1_vld_ff, s1_vld_in;
   logic                s2_vld_ff, s2_vld_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic                adv1, adv2, req_acc;
   logic [VOICE_AW-1:0] req_idx;

   assign req_idx   = VOICE_AW'(req_voice);
   assign adv2      = s2_vld_ff & (~rsp_vld_ff | rsp_ready);
   assign adv1      = s1_vld_ff & (~s2_vld_ff | adv2);
   assign req_ready = ~fill_ff & (~s1_vld_ff | adv1);
   assign req_acc   = req_valid & req_ready;

   assign s1_vld_in  = req_acc | (s1_vld_ff & ~adv1);
   assign s2_vld_in  = adv1 | (s2_vld_ff & ~adv2);
   assign rsp_vld_in = adv2 | (rsp_vld_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // phase store with per-voice valid bits and same-voice forwarding
   logic [VOICES-1:0]   phase_vld_ff, phase_vld_in;
   logic [VOICE_AW-1:0] s1_voice_ff, s1_voice_in;
   logic                s1_fwd_ff, s1_fwd_in;
   logic                s1_init_ff, s1_init_in;
   logic [PHASE_W-1:0]  fwd_phase_ff, fwd_phase_in;
   logic [PHASE_W-1:0]  phase_rd, phase_old, phase_new;
   logic [SUM_W-1:0]    phase_sum;

   always_comb begin
      phase_vld_in = phase_vld_ff;
      if (adv1) begin
         phase_vld_in[s1_voice_ff] = 1'b1;
      end
   end

   always_comb begin
      s1_voice_in  = s1_voice_ff;
      s1_fwd_in    = s1_fwd_ff;
      s1_init_in   = s1_init_ff;
      fwd_phase_in = adv1 ? phase_new : fwd_phase_ff;
      if (req_acc) begin
         s1_voice_in = req_idx;
         s1_fwd_in   = adv1 & (s1_voice_ff == req_idx);
         s1_init_in  = phase_vld_ff[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_vld_ff <= '0;
      end else begin
         phase_vld_ff <= phase_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_voice_ff  <= s1_voice_in;
      s1_fwd_ff    <= s1_fwd_in;
      s1_init_ff   <= s1_init_in;
      fwd_phase_ff <= fwd_phase_in;
   end

   always_comb begin
      if (s1_fwd_ff) begin
         phase_old = fwd_phase_ff;
      end else if (s1_init_ff) begin
         phase_old = phase_rd;
      end else begin
         phase_old = '0;
      end
      phase_sum = {1'b0, phase_old} + {1'b0, step_ff};
      if (phase_sum >= WRAP_TWO) begin
         phase_new = PHASE_W'(phase_sum - WRAP_TWO);
      end else if (phase_sum >= WRAP_ONE) begin
         phase_new = PHASE_W'(phase_sum - WRAP_ONE);
      end else begin
         phase_new = phase_sum[PHASE_W-1:0];
      end
   end

   wpng_ram #(
      .WIDTH (PHASE_W),
      .DEPTH (VOICES)
   ) u_phase_ram (
      .clock   (clock),
      .wr_en   (adv1),
      .wr_addr (s1_voice_ff),
      .wr_data (phase_new),
      .rd_en   (req_acc),
      .rd_addr (req_idx),
      .rd_data (phase_rd)
   );

   // noise table
   logic [SAMPLE_W-1:0] noise_rd;

   wpng_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (TABLE_SIZE)
   ) u_noise_ram (
      .clock   (clock),
      .wr_en   (fill_ff),
      .wr_addr (fill_addr_ff),
      .wr_data (xs_next[XS_W-1 -: SAMPLE_W]),
      .rd_en   (adv1),
      .rd_addr (phase_new[FRAC_W +: ROM_AW]),
      .rd_data (noise_rd)
   );

   // pink filter: c*(pink - white) + white*32768, floor by 2^15, saturate
   logic signed [SAMPLE_W-1:0] pink_ff, pink_in;
   logic signed [SAMPLE_W-1:0] white, pink_new;
   logic signed [SAMPLE_W:0]   diff;
   logic signed [COEF_W:0]     coef_s;
   logic signed [PROD_W-1:0]   prod;
   logic signed [ACC_W-1:0]    acc;
   logic signed [Q_W-1:0]      q;
   logic [SAMPLE_W-1:0]        rsp_white_ff, rsp_white_in;
   logic [SAMPLE_W-1:0]        rsp_pink_ff, rsp_pink_in;

   assign white  = signed'(noise_rd);
   assign diff   = {pink_ff[SAMPLE_W-1], pink_ff} - {white[SAMPLE_W-1], white};
   assign coef_s = signed'({1'b0, coef_ff});
   assign prod   = coef_s * diff;
   assign acc    = {prod[PROD_W-1], prod}
                 + {{(ACC_W-SAMPLE_W-Q15_W){white[SAMPLE_W-1]}}, white, {Q15_W{1'b0}}};
   assign q      = acc[ACC_W-1:Q15_W];

   always_comb begin
      if (!q[Q_W-1] && (q[Q_W-2:SAMPLE_W-1] != '0)) begin
         pink_new = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (q[Q_W-1] && (q[Q_W-2:SAMPLE_W-1] != '1)) begin
         pink_new = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         pink_new = q[SAMPLE_W-1:0];
      end
   end

   assign pink_in      = adv2 ? pink_new : pink_ff;
   assign rsp_white_in = adv2 ? noise_rd : rsp_white_ff;
   assign rsp_pink_in  = adv2 ? pink_new : rsp_pink_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pink_ff <= '0;
      end else begin
         pink_ff <= pink_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_white_ff <= rsp_white_in;
      rsp_pink_ff  <= rsp_pink_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_white = signed'(rsp_white_ff);
   assign rsp_pink  = signed'(rsp_pink_ff);

endmodule

// File: design/wpng_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpng_checker
// Port-level checks of the white and pink noise generator, bound to the top.
// ----------------------------------------------------------------------------
module wpng_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [wpng_pkg::SAMPLE_W-1:0] rsp_white,
   input logic signed [wpng_pkg::SAMPLE_W-1:0] rsp_pink
);

   // requests in flight
   logic [2:0] cnt_ff, cnt_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid & req_ready;
   assign rsp_acc = rsp_valid & rsp_ready;
   assign cnt_in  = cnt_ff + {2'b00, req_acc} - {2'b00, rsp_acc};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_white) && $stable(rsp_pink))
      else $error("response changed while stalled");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != 3'd0)
      else $error("response without an outstanding request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd3)
      else $error("more than three requests in flight");

   a_fill: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken before noise table fill");

endmodule

bind white_pink_noise_generator_unit wpng_checker u_wpng_checker (.*);

// File: bench/white_pink_noise_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// white_pink_noise_checker
// Watches the request, response and register ports of the noise generator,
// keeps its own copy of the voice phases, noise table, pink filter and
// registers, predicts white and pink samples per accepted request and compares
// them in order with the accepted responses.
// ----------------------------------------------------------------------------
module white_pink_noise_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [wpng_pkg::VOICE_W-1:0]         req_voice,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [wpng_pkg::SAMPLE_W-1:0] rsp_white,
   input  logic signed [wpng_pkg::SAMPLE_W-1:0] rsp_pink,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic                                 pready,
   input  logic [wpng_pkg::CSR_AW-1:0]          paddr,
   input  logic [wpng_pkg::CSR_DW-1:0]          pwdata,
   output int                                   errors,
   output int                                   pending
);

   import wpng_pkg::*;

   localparam longint unsigned WRAP_LIMIT = longint'(TABLE_SIZE) << FRAC_W;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] white;
      logic signed [SAMPLE_W-1:0] pink;
   } noise_sample_type;

   logic signed [SAMPLE_W-1:0] noise_words [TABLE_SIZE];
   logic [PHASE_W-1:0]         phase_acc [VOICES];
   logic signed [SAMPLE_W-1:0] pink_level;
   logic [PHASE_W-1:0]         step_reg;
   logic [COEF_W-1:0]          coef_reg;
   noise_sample_type           expected_samples [$];
   int                         err_count = 0;

   initial begin : fill_table
      logic [31:0] state;
      state = 32'hA5C3412F;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         state = state ^ (state << 13);
         state = state ^ (state >> 17);
         state = state ^ (state << 5);
         noise_words[i] = state[31:16];
      end
   end

   function automatic noise_sample_type advance_voice(input logic [VOICE_W-1:0] voice);
      int                         slot;
      longint unsigned            sum;
      int                         idx;
      logic signed [SAMPLE_W-1:0] white_v;
      longint                     acc;
      longint                     level;
      noise_sample_type           sample;
      slot = int'(voice) % VOICES;
      sum = longint'(phase_acc[slot]) + longint'(step_reg);
      sum = sum % WRAP_LIMIT;
      phase_acc[slot] = sum[PHASE_W-1:0];
      idx = int'(sum >> FRAC_W);
      white_v = noise_words[idx];
      acc = longint'(coef_reg) * longint'(pink_level)
          + (longint'(32768) - longint'(coef_reg)) * longint'(white_v);
      level = acc >>> Q15_W;
      if (level > 32767) level = 32767;
      if (level < -32768) level = -32768;
      pink_level = level[SAMPLE_W-1:0];
      sample.white = white_v;
      sample.pink = pink_level;
      return sample;
   endfunction

   always @(posedge clock) begin : watch
      noise_sample_type want;
      if (reset) begin
         foreach (phase_acc[i]) phase_acc[i] = '0;
         pink_level = '0;
         step_reg = STEP_RESET;
         coef_reg = COEF_RESET;
         expected_samples.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
            case (csr_index_type'(paddr[2]))
               REG_NOISE_STEP: step_reg = pwdata[PHASE_W-1:0];
               REG_PINK_COEF:  coef_reg = pwdata[COEF_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t unexpected response: white %0d pink %0d",
                        $time, rsp_white, rsp_pink);
               err_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_white !== want.white) begin
                  $display("%0t white mismatch: expected %0d actual %0d",
                           $time, want.white, rsp_white);
                  err_count++;
               end
               if (rsp_pink !== want.pink) begin
                  $display("%0t pink mismatch: expected %0d actual %0d",
                           $time, want.pink, rsp_pink);
                  err_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_samples.push_back(advance_voice(req_voice));
         end
      end
      pending <= expected_samples.size();
      errors <= err_count;
   end

endmodule

// File: bench/tb_white_pink_noise_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_white_pink_noise_generator_unit
// Drives voice requests and register writes into the noise generator with
// random gaps on the request and response channels, across several step and
// coefficient settings including the wrap limit and coefficients above unity,
// and reports the verdict from the checker's error and pending counts.
// ----------------------------------------------------------------------------
module tb_white_pink_noise_generator_unit;
   import wpng_pkg::*;

   localparam int unsigned WRAP_LIMIT = TABLE_SIZE << FRAC_W;
   localparam int unsigned STEP_MAX   = (1 << PHASE_W) - 1;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [VOICE_W-1:0]         req_voice = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_white;
   logic signed [SAMPLE_W-1:0] rsp_pink;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [CSR_AW-1:0]          paddr = '0;
   logic [CSR_DW-1:0]          pwdata = '0;
   logic [CSR_DW-1:0]          prdata;
   logic                       pready;
   int                         errors;
   int                         pending;
   int                         sender_idle_pct = 15;
   int                         receiver_idle_pct = 88;

   white_pink_noise_generator_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_voice (req_voice),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_white (rsp_white),
      .rsp_pink  (rsp_pink),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   white_pink_noise_checker checker_i (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_voice (req_voice),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_white (rsp_white),
      .rsp_pink  (rsp_pink),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .pready    (pready),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .errors    (errors),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   task automatic send_voice(input logic [VOICE_W-1:0] voice);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_voice <= voice;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold requests until every response is back, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type reg_index,
                                 input logic [CSR_DW-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [CSR_DW-1:0] pick_step();
      logic [CSR_DW-1:0] step;
      case ($urandom_range(0, 6))
         0:       step = $urandom_range(0, 65535);
         1:       step = $urandom & STEP_MAX;
         2:       step = WRAP_LIMIT - 1 - $urandom_range(0, 1000);
         3:       step = $urandom_range(WRAP_LIMIT, STEP_MAX);
         4:       step = $urandom_range(1, 16) << FRAC_W;
         5:       step = CSR_DW'(STEP_RESET);
         default: step = $urandom_range(0, WRAP_LIMIT - 1);
      endcase
      // upper bits beyond the register width are don't-care
      return step | ($urandom & ~STEP_MAX);
   endfunction

   function automatic logic [CSR_DW-1:0] pick_coef();
      logic [CSR_DW-1:0] coef;
      case ($urandom_range(0, 7))
         0:       coef = 0;
         1:       coef = 32768;
         2:       coef = $urandom_range(32769, 65535);
         3:       coef = CSR_DW'(COEF_RESET);
         default: coef = $urandom_range(0, 32768);
      endcase
      return coef | ($urandom & 32'hFFFF0000);
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // noise table fill
      do @(posedge clock); while (!req_ready);

      // reset settings
      for (int v = 0; v < VOICES; v++) send_voice(VOICE_W'(v));
      settle();

      // pink follows white
      write_register(REG_NOISE_STEP, 32'd0);
      write_register(REG_PINK_COEF, 32'd0);
      send_voice(0);
      send_voice(7);
      settle();

      // largest step, pink held
      write_register(REG_NOISE_STEP, STEP_MAX);
      write_register(REG_PINK_COEF, 32'd32768);
      send_voice(1);
      send_voice(1);
      send_voice(1);
      send_voice(6);
      settle();

      // step just under the wrap, coefficient driving saturation
      write_register(REG_NOISE_STEP, WRAP_LIMIT - 1);
      write_register(REG_PINK_COEF, 32'd65535);
      send_voice(2);
      send_voice(2);
      send_voice(2);
      send_voice(2);
      send_voice(5);
      send_voice(5);
      settle();

      // step equal to the wrap
      write_register(REG_NOISE_STEP, WRAP_LIMIT);
      write_register(REG_PINK_COEF, 32'd1);
      send_voice(3);
      send_voice(3);
      send_voice(4);
      settle();

      for (int phase_n = 0; phase_n < 7; phase_n++) begin
         if (phase_n < 2) begin
            sender_idle_pct = 15;
            receiver_idle_pct = 88;
         end else if (phase_n < 4) begin
            sender_idle_pct = 88;
            receiver_idle_pct = 15;
         end else begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         write_register(REG_NOISE_STEP, pick_step());
         write_register(REG_PINK_COEF, pick_coef());
         for (int n = 0; n < 250; n++) begin
            send_voice(VOICE_W'($urandom_range(0, 7)));
            if (phase_n == 1 && n == 125) settle();
         end
         settle();
      end

      repeat (10) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
